>>> hw/rtl/acm_pkg.sv
package acm_pkg;

  // Item kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_ATTR = 2'd1,
    MODE_LINE = 2'd2
  } acm_mode_e;

  // Per-entry match state while a command line is scanned.
  typedef enum logic [1:0] {
    OUT_PENDING = 2'd0,
    OUT_FULL    = 2'd1,
    OUT_ABBREV  = 2'd2,
    OUT_FAILED  = 2'd3
  } acm_outcome_e;

  // Character codes.
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TBL_SPACE = 8'h80;
  localparam logic [7:0] CHAR_LOW_A     = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z     = 8'h7A;
  localparam logic [7:0] CASE_BIT       = 8'h20;

  // Length of the header that the returned offset counts.
  localparam int HDR_BYTES = 5;

  // Table load traffic, decoded at the input transfer.
  typedef struct packed {
    logic       char_we;
    logic       attr_we;
    logic       rd_en;
    logic [4:0] entry;
    logic [3:0] char_pos;
    logic [7:0] value;
    logic [4:0] word_length;
    logic [4:0] abbrev_min;
  } acm_load_t;

  // Line character broadcast to all entries from the input register.
  typedef struct packed {
    logic       upd;
    logic       clear;
    logic       last;
    logic [7:0] ch;
  } acm_line_t;

endpackage

>>> hw/rtl/acm_cmd_if.sv
interface acm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [4:0] entry;
  logic [3:0] char_pos;
  logic [7:0] value;
  logic [4:0] word_length;
  logic [4:0] abbrev_min;
  logic       line_end;

  modport source (
    output valid, mode, entry, char_pos, value, word_length, abbrev_min, line_end,
    input  ready
  );

  modport sink (
    input  valid, mode, entry, char_pos, value, word_length, abbrev_min, line_end,
    output ready
  );
endinterface

>>> hw/rtl/acm_res_if.sv
interface acm_res_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [4:0] command_index;
  logic [7:0] next_index;
  logic       by_abbreviation;

  modport source (
    output valid, found, command_index, next_index, by_abbreviation,
    input  ready
  );

  modport sink (
    input  valid, found, command_index, next_index, by_abbreviation,
    output ready
  );
endinterface

>>> hw/rtl/abbreviated_command_matcher_top.sv
// A line character that decides the command passes the table read and input register,
// then the result register, before its result is shown.
// Throughput: one item per cycle unless stalled; all entries compare each character.
// Table loads take effect for the next item. The output register holds a result
// while the sink stalls and the input side stalls only when both stages are full.
// Reset (rst_ni low, asynchronous) clears the entry count, line state and handshakes;
// the command table itself is undefined until loaded.
module abbreviated_command_matcher_top import acm_pkg::*; #(
  parameter int MAX_COMMANDS = 32,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  acm_cmd_if.sink       cmd_i,
  acm_res_if.source     res_o,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_wdata_i
);

  localparam int AW = $clog2(MAX_WORD_LEN);
  localparam int PW = $clog2(MAX_WORD_LEN + 1);
  localparam int NW = $clog2(MAX_WORD_LEN + HDR_BYTES + 2);
  localparam int IW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;

  logic          accept;
  logic          s1_adv;
  logic [7:0]    ch_up;
  logic          s1_vld_q, s1_line_q, s1_last_q;
  logic [7:0]    s1_ch_q;
  logic [5:0]    cmd_count_q;
  logic [PW-1:0] line_pos_q, line_pos_d;
  logic          decided_q, decided_d;
  logic          line_go, upd, res_gen;
  acm_load_t     ld;
  acm_line_t     line_bc;
  acm_outcome_e  outc [MAX_COMMANDS];
  logic [NW-1:0] next_val [MAX_COMMANDS];
  logic          in_use [MAX_COMMANDS];
  logic          hit, open_any, win_abbr;
  logic [IW-1:0] win_idx;
  logic [NW-1:0] win_next;
  logic          out_vld_q, out_found_q, out_abbr_q;
  logic [4:0]    out_idx_q;
  logic [7:0]    out_next_q;

  // Input transfer and stage advance.
  assign s1_adv      = s1_vld_q && (!out_vld_q || res_o.ready);
  assign cmd_i.ready = !s1_vld_q || s1_adv;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Lower-case letters on the line are upper-cased.
  assign ch_up = ((cmd_i.value >= CHAR_LOW_A) && (cmd_i.value <= CHAR_LOW_Z)) ?
                 (cmd_i.value & ~CASE_BIT) : cmd_i.value;

  // Table loads are written at the transfer, so a later item sees them.
  always_comb begin
    ld.char_we     = accept && (cmd_i.mode == MODE_CHAR);
    ld.attr_we     = accept && (cmd_i.mode == MODE_ATTR);
    ld.rd_en       = accept;
    ld.entry       = cmd_i.entry;
    ld.char_pos    = cmd_i.char_pos;
    ld.value       = cmd_i.value;
    ld.word_length = cmd_i.word_length;
    ld.abbrev_min  = cmd_i.abbrev_min;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_line_q <= (cmd_i.mode == MODE_LINE);
      s1_last_q <= cmd_i.line_end;
      s1_ch_q   <= ch_up;
    end
  end

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_count_q <= '0;
    end else if (cfg_we_i) begin
      cmd_count_q <= cfg_wdata_i;
    end
  end

  // Line character broadcast.
  assign line_go = s1_adv && s1_line_q;
  assign upd     = line_go && !decided_q;

  always_comb begin
    line_bc.upd   = upd;
    line_bc.clear = line_go && s1_last_q;
    line_bc.last  = s1_last_q;
    line_bc.ch    = s1_ch_q;
  end

  // One lane per table entry.
  for (genvar g = 0; g < MAX_COMMANDS; g++) begin : g_lane
    assign in_use[g] = (g < int'(cmd_count_q));

    acm_lane #(
      .LANE         (g),
      .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ld_i      (ld),
      .rd_addr_i (line_pos_d[AW-1:0]),
      .line_i    (line_bc),
      .pos_i     (line_pos_q),
      .use_i     (in_use[g]),
      .outc_o    (outc[g]),
      .next_o    (next_val[g])
    );
  end

  // The lowest entry in use that has not failed decides the line.
  always_comb begin
    hit      = 1'b0;
    open_any = 1'b0;
    win_abbr = 1'b0;
    win_idx  = '0;
    win_next = '0;
    for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
      if (in_use[i] && (outc[i] != OUT_FAILED)) begin
        hit      = 1'b1;
        open_any = (outc[i] == OUT_PENDING);
        win_abbr = (outc[i] == OUT_ABBREV);
        win_idx  = IW'(i);
        win_next = next_val[i];
      end
    end
  end

  assign res_gen = upd && !open_any;

  // Line position and decided flag; a line end clears both.
  always_comb begin
    line_pos_d = line_pos_q;
    decided_d  = decided_q;
    if (line_go) begin
      if (s1_last_q) begin
        line_pos_d = '0;
        decided_d  = 1'b0;
      end else begin
        if (!decided_q && (line_pos_q != PW'(MAX_WORD_LEN))) begin
          line_pos_d = line_pos_q + PW'(1);
        end
        if (res_gen) begin
          decided_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q <= '0;
      decided_q  <= 1'b0;
    end else begin
      line_pos_q <= line_pos_d;
      decided_q  <= decided_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= res_gen;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_gen) begin
      out_found_q <= hit;
      out_idx_q   <= hit ? 5'(win_idx) : '0;
      out_next_q  <= hit ? 8'(win_next) : '0;
      out_abbr_q  <= hit && win_abbr;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.found           = out_found_q;
  assign res_o.command_index   = out_idx_q;
  assign res_o.next_index      = out_next_q;
  assign res_o.by_abbreviation = out_abbr_q;

`ifndef SYNTHESIS
  // A decided line has always moved past its first character.
  a_decided_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q |-> (line_pos_q != '0))
    else $error("decided set at line position zero");

  // A result within a line leaves the rest of it ignored.
  a_result_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_gen && !s1_last_q) |=> decided_q)
    else $error("result given without marking the line decided");

  // The end of a line always restarts matching.
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_go && s1_last_q) |=> ((line_pos_q == '0) && !decided_q))
    else $error("line state not cleared at line end");

  // Both stages full and the sink stalled: no new input transfer.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !res_o.ready) |-> !cmd_i.ready)
    else $error("input taken while both stages are blocked");
`endif

endmodule

>>> hw/rtl/acm_ram.sv
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/acm_lane.sv
module acm_lane import acm_pkg::*; #(
  parameter int LANE         = 0,
  parameter int MAX_WORD_LEN = 16,
  localparam int AW = $clog2(MAX_WORD_LEN),
  localparam int PW = $clog2(MAX_WORD_LEN + 1),
  localparam int NW = $clog2(MAX_WORD_LEN + HDR_BYTES + 2)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  acm_load_t    ld_i,
  input  logic [AW-1:0] rd_addr_i,
  input  acm_line_t    line_i,
  input  logic [PW-1:0] pos_i,
  input  logic         use_i,
  output acm_outcome_e outc_o,
  output logic [NW-1:0] next_o
);

  logic          char_we;
  logic [7:0]    tbl_ch;
  logic [PW-1:0] len_q;
  logic [4:0]    abbr_q;
  acm_outcome_e  outc_q, outc_eval, outc_d;
  logic [NW-1:0] next_q, next_eval;
  logic          ch_match;

  // Character store for this entry, one word position per address.
  assign char_we = ld_i.char_we && (int'(ld_i.entry) == LANE) &&
                   (int'(ld_i.char_pos) < MAX_WORD_LEN);

  acm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD_LEN)
  ) u_chars (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (AW'(ld_i.char_pos)),
    .wdata_i (ld_i.value),
    .re_i    (ld_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (tbl_ch)
  );

  // Word length, saturated to the widest word, and the shortest abbreviation.
  always_ff @(posedge clk_i) begin
    if (ld_i.attr_we && (int'(ld_i.entry) == LANE)) begin
      if (int'(ld_i.word_length) > MAX_WORD_LEN) begin
        len_q <= PW'(MAX_WORD_LEN);
      end else begin
        len_q <= PW'(ld_i.word_length);
      end
      abbr_q <= ld_i.abbrev_min;
    end
  end

  // A table byte 0x80 stands for a space on the line.
  assign ch_match = (line_i.ch == tbl_ch) ||
                    ((line_i.ch == CHAR_SPACE) && (tbl_ch == CHAR_TBL_SPACE));

  // Advance this entry by one line character.
  always_comb begin
    outc_eval = outc_q;
    next_eval = next_q;
    if (line_i.upd && use_i && (outc_q == OUT_PENDING)) begin
      if (int'(pos_i) >= int'(len_q)) begin
        outc_eval = OUT_FULL;
        next_eval = NW'(len_q) + NW'(HDR_BYTES);
      end else if ((line_i.ch == CHAR_CR) || (line_i.ch == CHAR_NUL)) begin
        outc_eval = OUT_FAILED;
      end else if ((pos_i != '0) && (line_i.ch == CHAR_DOT) &&
                   (int'(pos_i) >= int'(abbr_q))) begin
        outc_eval = OUT_ABBREV;
        next_eval = NW'(pos_i) + NW'(HDR_BYTES + 1);
      end else if (ch_match) begin
        if (int'(pos_i) + 1 == int'(len_q)) begin
          outc_eval = OUT_FULL;
          next_eval = NW'(len_q) + NW'(HDR_BYTES);
        end
      end else begin
        outc_eval = OUT_FAILED;
      end
      // The line ended while this entry was still open.
      if (line_i.last && (outc_eval == OUT_PENDING)) begin
        outc_eval = OUT_FAILED;
      end
    end
  end

  assign outc_d = line_i.clear ? OUT_PENDING : outc_eval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outc_q <= OUT_PENDING;
    end else begin
      outc_q <= outc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_eval;
  end

  assign outc_o = outc_eval;
  assign next_o = next_eval;

endmodule
